>>> rtl/xed_pkg.sv
// Shared types and constants for the XML entity decoder.
// Used by xed_scan and xml_entity_decoder; no dependencies.
package xed_pkg;

  // Default reference window depth, '&' included
  localparam int WINDOW_DEF = 12;

  // Code point and accumulator widths
  localparam int CP_W  = 21;
  localparam int ACC_W = 25;

  // Character codes
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;

  // Code point limits
  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SAT = 21'h110000;
  localparam logic [CP_W-1:0] SUR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SUR_HI = 21'h00DFFF;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF_CONT  = 8'h80;
  localparam logic [5:0] UTF_MASK  = 6'h3F;

  // Decoder sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_VERB,
    ST_SEMI,
    ST_UTF,
    ST_FLUSH,
    ST_FIN
  } state_t;

  // Scanner verdict on the open reference
  typedef struct packed {
    logic            name_hit;
    logic [7:0]      name_char;
    logic            num_hit;
    logic [CP_W-1:0] cp;
  } scan_res_t;

endpackage

>>> rtl/xed_scan.sv
// Reference scanner: tracks name matches and the numeric value as bytes
// enter the window. Depends on xed_pkg.
module xed_scan
  import xed_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  localparam int IW = $clog2(WINDOW)
) (
  input  logic          clk,
  input  logic          push,
  input  logic [7:0]    push_byte,
  input  logic [IW-1:0] len,
  output scan_res_t     res
);

  typedef enum logic [2:0] {
    ENT_AMP,
    ENT_LT,
    ENT_GT,
    ENT_QUOT,
    ENT_APOS
  } ent_t;

  localparam int NUM_ENT = 5;

  function automatic logic [2:0] ent_len(ent_t e);
    case (e)
      ENT_AMP:  ent_len = 3'd3;
      ENT_LT:   ent_len = 3'd2;
      ENT_GT:   ent_len = 3'd2;
      ENT_QUOT: ent_len = 3'd4;
      ENT_APOS: ent_len = 3'd4;
      default:  ent_len = 3'd0;
    endcase
  endfunction

  function automatic logic [31:0] ent_word(ent_t e);
    case (e)
      ENT_AMP:  ent_word = 32'h616D7000;
      ENT_LT:   ent_word = 32'h6C740000;
      ENT_GT:   ent_word = 32'h67740000;
      ENT_QUOT: ent_word = 32'h71756F74;
      ENT_APOS: ent_word = 32'h61706F73;
      default:  ent_word = 32'h00000000;
    endcase
  endfunction

  function automatic logic [7:0] ent_out(ent_t e);
    case (e)
      ENT_AMP:  ent_out = 8'h26;
      ENT_LT:   ent_out = 8'h3C;
      ENT_GT:   ent_out = 8'h3E;
      ENT_QUOT: ent_out = 8'h22;
      ENT_APOS: ent_out = 8'h27;
      default:  ent_out = 8'h00;
    endcase
  endfunction

  logic [NUM_ENT-1:0] match_r, match_nxt;
  logic               num_ok_r;
  logic               hex_r;
  logic               dig_r;
  logic [CP_W-1:0]    v_r;

  logic               is_dec, is_lo, is_up, dig_ok, is_x;
  logic [3:0]         dval;
  logic [ACC_W-1:0]   acc;
  logic [CP_W-1:0]    v_sat;

  // Compare the incoming byte against each name at its position
  always_comb begin
    ent_t        e;
    logic [31:0] w;
    for (int i = 0; i < NUM_ENT; i++) begin
      e = ent_t'(i);
      w = ent_word(e);
      match_nxt[i] = ((len == '0) || match_r[i]) && (len < IW'(ent_len(e)))
                     && (push_byte == w[8*(3 - int'(len[1:0])) +: 8]);
    end
  end

  // Digit decode and one multiply-add step
  always_comb begin
    is_dec = (push_byte >= 8'h30) && (push_byte <= 8'h39);
    is_lo  = (push_byte >= 8'h61) && (push_byte <= 8'h66);
    is_up  = (push_byte >= 8'h41) && (push_byte <= 8'h46);
    is_x   = (push_byte == CH_X_LO) || (push_byte == CH_X_UP);
    dig_ok = hex_r ? (is_dec || is_lo || is_up) : is_dec;
    dval   = is_dec ? push_byte[3:0] : (push_byte[3:0] + 4'd9);
    if (hex_r) begin
      acc = {v_r, 4'b0000} + ACC_W'(dval);
    end else begin
      acc = ACC_W'({v_r, 3'b000}) + ACC_W'({v_r, 1'b0}) + ACC_W'(dval);
    end
    v_sat = (acc > ACC_W'(CP_MAX)) ? CP_SAT : acc[CP_W-1:0];
  end

  // Advance the scan on each pushed byte
  always_ff @(posedge clk) begin
    if (push) begin
      match_r <= match_nxt;
      if (len == '0) begin
        num_ok_r <= (push_byte == CH_HASH);
        hex_r    <= 1'b0;
        dig_r    <= 1'b0;
        v_r      <= '0;
      end else if ((len == IW'(1)) && is_x) begin
        hex_r <= 1'b1;
      end else if (dig_ok) begin
        v_r   <= v_sat;
        dig_r <= 1'b1;
      end else begin
        num_ok_r <= 1'b0;
      end
    end
  end

  // Resolve the verdict for the current length
  always_comb begin
    ent_t e;
    res.name_hit  = 1'b0;
    res.name_char = 8'h00;
    for (int i = 0; i < NUM_ENT; i++) begin
      e = ent_t'(i);
      if (match_r[i] && (len == IW'(ent_len(e)))) begin
        res.name_hit  = 1'b1;
        res.name_char = ent_out(e);
      end
    end
    res.cp      = v_r;
    res.num_hit = (len != '0) && num_ok_r && dig_r && (v_r != '0) && (v_r <= CP_MAX)
                  && !((v_r >= SUR_LO) && (v_r <= SUR_HI));
  end

endmodule

>>> rtl/xml_entity_decoder.sv
// Top level of the XML entity decoder: window, take sequencer, output stage.
// Depends on xed_pkg and xed_scan.
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+----------
//   input   | in_valid, in_stall, in_byte, in_last     | in
//   result  | out_valid, out_stall, out_byte, out_last | out
//
// One request at a time: accept, then a pass through ST_TAKE per byte handled (a literal,
// a named character or the overflow '&' leaves in that pass), ST_VERB, ST_SEMI, ST_UTF
// or ST_FLUSH for each further emitted byte, then ST_FIN to close the request.
// A window overflow replays the buffered bytes through the single window read
// port, one at a time, each one taken again in ST_TAKE.
// Reset (rst_n low, synchronous) empties the window; no clearing pass is needed.
// A stalled output holds the sequencer whenever a new byte must be emitted while one
// is still held back, or the request closes with a byte still held back.
module xml_entity_decoder
  import xed_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam int IW = $clog2(WINDOW);
  localparam int FW = $clog2(WINDOW + 1);

  // Byte k of an n-byte UTF-8 sequence (nm1 = n - 1)
  function automatic logic [7:0] utf8_byte(logic [CP_W-1:0] cp, logic [1:0] nm1,
                                           logic [1:0] k);
    int              s;
    logic [CP_W-1:0] sh;
    logic [7:0]      b;
    s  = 6 * (int'(nm1) - int'(k));
    sh = cp >> s;
    b  = 8'h00;
    if (k == 2'd0) begin
      case (nm1)
        2'd0:    b = sh[7:0];
        2'd1:    b = UTF_LEAD2 | sh[7:0];
        2'd2:    b = UTF_LEAD3 | sh[7:0];
        2'd3:    b = UTF_LEAD4 | sh[7:0];
        default: b = 8'h00;
      endcase
    end else begin
      b = UTF_CONT | {2'b00, sh[5:0] & UTF_MASK};
    end
    return b;
  endfunction

  state_t          state_r, state_nxt;
  logic [7:0]      win_r [WINDOW];
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [FW-1:0]   rp_r, rp_nxt;
  logic            rpl_r, rpl_nxt;
  logic [IW-1:0]   ep_r, ep_nxt;
  logic [1:0]      uk_r, uk_nxt;
  logic [7:0]      cur_byte_r;
  logic            cur_last_r;
  logic            pend_valid_r, pend_valid_nxt;
  logic [7:0]      pend_byte_r, pend_byte_nxt;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;

  logic            in_take;
  logic            out_free;
  logic [IW-1:0]   rd_idx;
  logic [7:0]      rd_data;
  logic            rp_last;
  logic [7:0]      tb;
  logic            fill_zero, fill_full;
  logic            act_lit, act_open, act_semi, act_push, act_ovf;
  logic            emit_req, fin_req, go, move;
  logic [7:0]      emit_byte;
  logic            ep_last, uk_last, take_done;
  logic [1:0]      ulen_m1;
  logic [FW-1:0]   fill_m1;
  logic            win_we;
  logic [IW-1:0]   win_wa;
  logic            scan_push;
  scan_res_t       scan_res;

  xed_scan #(.WINDOW(WINDOW)) u_scan (
    .clk       (clk),
    .push      (scan_push),
    .push_byte (tb),
    .len       (fill_m1[IW-1:0]),
    .res       (scan_res)
  );

  // Decode the byte under take and the emit request
  always_comb begin
    in_take   = in_valid && (state_r == ST_IDLE);
    out_free  = !out_valid_r || !out_stall;
    rd_idx    = (state_r == ST_TAKE) ? rp_r[IW-1:0] : ep_r;
    rd_data   = win_r[rd_idx];
    rp_last   = (rp_r == FW'(WINDOW));
    tb        = (rpl_r && !rp_last) ? rd_data : cur_byte_r;
    fill_zero = (fill_r == '0);
    fill_full = (fill_r == FW'(WINDOW));
    fill_m1   = fill_r - FW'(1);
    act_lit   = fill_zero && (tb != CH_AMP);
    act_open  = fill_zero && (tb == CH_AMP);
    act_semi  = !fill_zero && (tb == CH_SEMI);
    act_push  = !fill_zero && (tb != CH_SEMI) && !fill_full;
    act_ovf   = !fill_zero && (tb != CH_SEMI) && fill_full;
    if (scan_res.cp < 21'h000080)      ulen_m1 = 2'd0;
    else if (scan_res.cp < 21'h000800) ulen_m1 = 2'd1;
    else if (scan_res.cp < 21'h010000) ulen_m1 = 2'd2;
    else                               ulen_m1 = 2'd3;
    ep_last = ((FW'(ep_r) + FW'(1)) == fill_r);
    uk_last = (uk_r == ulen_m1);

    emit_req  = 1'b0;
    emit_byte = 8'h00;
    case (state_r)
      ST_TAKE: begin
        emit_req = act_lit || act_ovf || (act_semi && scan_res.name_hit);
        if (act_lit)      emit_byte = tb;
        else if (act_ovf) emit_byte = CH_AMP;
        else              emit_byte = scan_res.name_char;
      end
      ST_VERB, ST_FLUSH: begin
        emit_req  = 1'b1;
        emit_byte = rd_data;
      end
      ST_SEMI: begin
        emit_req  = 1'b1;
        emit_byte = CH_SEMI;
      end
      ST_UTF: begin
        emit_req  = 1'b1;
        emit_byte = utf8_byte(scan_res.cp, ulen_m1, uk_r);
      end
      default: begin
        emit_req  = 1'b0;
        emit_byte = 8'h00;
      end
    endcase
    fin_req   = (state_r == ST_FIN);
    go        = !((emit_req || fin_req) && pend_valid_r) || out_free;
    move      = go && (emit_req || fin_req) && pend_valid_r;
    take_done = go && (((state_r == ST_TAKE)
                        && (act_lit || act_open || act_push
                            || (act_semi && scan_res.name_hit)))
                       || (state_r == ST_SEMI)
                       || ((state_r == ST_UTF) && uk_last));
    scan_push = (state_r == ST_TAKE) && go && act_push;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_TAKE;
      end
      ST_TAKE: begin
        if (go && act_semi && !scan_res.name_hit) begin
          state_nxt = scan_res.num_hit ? ST_UTF : ST_VERB;
        end
      end
      ST_VERB: begin
        if (go && ep_last) state_nxt = ST_SEMI;
      end
      ST_FLUSH: begin
        if (go && ep_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (go) state_nxt = ST_IDLE;
      end
      default: state_nxt = state_r;
    endcase
    if (take_done) begin
      if (rpl_r && !rp_last)                  state_nxt = ST_TAKE;
      else if (cur_last_r && fill_nxt != '0)  state_nxt = ST_FLUSH;
      else                                    state_nxt = ST_FIN;
    end
  end

  // Datapath next values
  always_comb begin
    fill_nxt       = fill_r;
    rp_nxt         = rp_r;
    rpl_nxt        = rpl_r;
    ep_nxt         = ep_r;
    uk_nxt         = uk_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    win_we         = 1'b0;
    win_wa         = fill_r[IW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) rpl_nxt = 1'b0;
      end
      ST_TAKE: begin
        if (go) begin
          if (act_open) begin
            win_we   = 1'b1;
            win_wa   = '0;
            fill_nxt = FW'(1);
          end else if (act_push) begin
            win_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end else if (act_semi) begin
            if (scan_res.name_hit) begin
              fill_nxt = '0;
            end else if (scan_res.num_hit) begin
              fill_nxt = '0;
              uk_nxt   = '0;
            end else begin
              ep_nxt = '0;
            end
          end else if (act_ovf) begin
            fill_nxt = '0;
            rpl_nxt  = 1'b1;
            rp_nxt   = FW'(1);
          end
        end
      end
      ST_VERB: begin
        if (go && !ep_last) ep_nxt = ep_r + IW'(1);
      end
      ST_SEMI: begin
        if (go) fill_nxt = '0;
      end
      ST_UTF: begin
        if (go) uk_nxt = uk_r + 2'd1;
      end
      ST_FLUSH: begin
        if (go) begin
          if (ep_last) fill_nxt = '0;
          else         ep_nxt   = ep_r + IW'(1);
        end
      end
      ST_FIN: begin
        if (go) pend_valid_nxt = 1'b0;
      end
      default: begin
        fill_nxt = fill_r;
      end
    endcase

    // Advance the replay after each completed take
    if (take_done) begin
      ep_nxt = '0;
      if (rpl_r) begin
        if (rp_last) rpl_nxt = 1'b0;
        else         rp_nxt  = rp_r + FW'(1);
      end
    end

    // Hold one byte back so the final one can carry out_last
    if (go && emit_req) begin
      pend_valid_nxt = 1'b1;
      pend_byte_nxt  = emit_byte;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      rpl_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      rpl_r        <= rpl_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (move)           out_valid_r <= 1'b1;
      else if (out_free)  out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rp_r        <= rp_nxt;
    ep_r        <= ep_nxt;
    uk_r        <= uk_nxt;
    pend_byte_r <= pend_byte_nxt;
    if (in_take) begin
      cur_byte_r <= in_byte;
      cur_last_r <= in_last;
    end
    if (win_we) win_r[win_wa] <= tb;
    if (move) begin
      out_byte_r <= pend_byte_r;
      out_last_r <= fin_req && cur_last_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

>>> rtl/xed_checker.sv
// Port-level checks for xml_entity_decoder, attached by bind.
// No package dependencies.
module xed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result changed");

  // Block further requests while one is in work
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken before the first finished");

  // Raise no result while the block stays idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && $past(!in_stall) |-> !$rose(out_valid))
    else $error("result appeared while idle");

endmodule

bind xml_entity_decoder xed_checker u_xed_checker (.*);
